/* src/xxh_pkg.sv */
// Shared constants, command/status types and helpers for the xxHash64 stream block.
// Used by xxh_datapath, xxh_ctrl, xxhash64_stream and the testbench; depends on nothing.
package xxh_pkg;

    localparam logic [63:0] PRIME1     = 64'd11400714785074694791;
    localparam logic [63:0] PRIME2     = 64'd14029467366897019727;
    localparam logic [63:0] PRIME3     = 64'd1609587929392839161;
    localparam logic [63:0] PRIME4     = 64'd9650029242287828579;
    localparam logic [63:0] PRIME5     = 64'd2870177450012600261;
    localparam logic [63:0] SEED_RESET = 64'h4f1bbcdc6762f36b;

    // Operand register sources
    localparam logic [3:0] A_NONE   = 4'd0;
    localparam logic [3:0] A_BUF    = 4'd1;
    localparam logic [3:0] A_LSUM   = 4'd2;
    localparam logic [3:0] A_ROT31R = 4'd3;
    localparam logic [3:0] A_LANE   = 4'd4;
    localparam logic [3:0] A_H      = 4'd5;
    localparam logic [3:0] A_ROT27H = 4'd6;
    localparam logic [3:0] A_ROT23H = 4'd7;
    localparam logic [3:0] A_ROT11H = 4'd8;
    localparam logic [3:0] A_X32    = 4'd9;
    localparam logic [3:0] A_X8     = 4'd10;

    // Multiplier constant select
    localparam logic [1:0] C_P1 = 2'd0;
    localparam logic [1:0] C_P2 = 2'd1;
    localparam logic [1:0] C_P3 = 2'd2;
    localparam logic [1:0] C_P5 = 2'd3;

    // Write-back operations
    localparam logic [3:0] WB_NONE   = 4'd0;
    localparam logic [3:0] WB_ACCEPT = 4'd1;
    localparam logic [3:0] WB_LANE   = 4'd2;
    localparam logic [3:0] WB_HXOR   = 4'd3;
    localparam logic [3:0] WB_HP4    = 4'd4;
    localparam logic [3:0] WB_T4     = 4'd5;
    localparam logic [3:0] WB_T1     = 4'd6;
    localparam logic [3:0] WB_HSET   = 4'd7;
    localparam logic [3:0] WB_MERGE  = 4'd8;
    localparam logic [3:0] WB_SHORT  = 4'd9;
    localparam logic [3:0] WB_HLEN   = 4'd10;
    localparam logic [3:0] WB_AV33   = 4'd11;
    localparam logic [3:0] WB_AV29   = 4'd12;
    localparam logic [3:0] WB_OUT    = 4'd13;

    typedef struct packed {
        logic [3:0] a_sel;
        logic [1:0] c_sel;
        logic       mul;
        logic [3:0] wb;
        logic [1:0] k;
        logic       clr_fill;
    } xxh_cmd_t;

    typedef struct packed {
        logic       mul_done;
        logic       fill_full;
        logic       last;
        logic       len_ge32;
        logic [1:0] nbuf;
        logic [2:0] rem;
        logic       out_free;
    } xxh_status_t;

    function automatic logic [63:0] rol64(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

endpackage

/* src/xxh_mul.sv */
// 64x64 multiply, low 64 bits, from three partial products on one 32x32 multiplier.
// Depends on no other file.
module xxh_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        run,
    input  logic [63:0] a,
    input  logic [63:0] c,
    output logic [63:0] r,
    output logic        done
);
    logic [1:0]  cnt_reg;
    logic [63:0] p_reg;
    logic [31:0] t_reg;
    logic [63:0] r_reg;
    logic [31:0] ma, mb;
    logic [63:0] prod;

    // Pick the partial product for this step
    always_comb begin
        case (cnt_reg)
            2'd0: begin
                ma = a[31:0];
                mb = c[31:0];
            end
            2'd1: begin
                ma = a[31:0];
                mb = c[63:32];
            end
            default: begin
                ma = a[63:32];
                mb = c[31:0];
            end
        endcase
    end

    assign prod = ma * mb;
    assign done = run && (cnt_reg == 2'd2);
    assign r    = r_reg;

    // Advance the step counter while running
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (!run || cnt_reg == 2'd2) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    // Accumulate partial products
    always_ff @(posedge aclk) begin
        if (run) begin
            case (cnt_reg)
                2'd0: p_reg <= prod;
                2'd1: t_reg <= prod[31:0];
                default: r_reg <= p_reg + {t_reg + prod[31:0], 32'd0};
            endcase
        end
    end

endmodule

/* src/xxh_datapath.sv */
// Datapath: seed, lanes, stripe buffer, length, hash and operand registers, output register.
// Depends on xxh_pkg and xxh_mul.
module xxh_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  xxh_pkg::xxh_cmd_t cmd,
    output xxh_pkg::xxh_status_t status,
    input  logic [63:0]      in_word,
    input  logic [3:0]       in_vb,
    input  logic             in_last,
    input  logic             cfg_valid,
    input  logic [63:0]      cfg_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [63:0]      out_digest
);
    import xxh_pkg::*;

    logic [63:0] seed_reg;
    logic [63:0] lane_reg [4];
    logic [63:0] buf_reg [4];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [63:0] x_reg;
    logic [2:0]  rem_reg;
    logic        last_reg;
    logic [63:0] h_reg;
    logic [63:0] a_reg;
    logic        out_valid_reg;
    logic [63:0] digest_reg;

    logic [3:0]  v;
    logic [63:0] mask, wm;
    logic        full_word;
    logic [63:0] cval, r;
    logic        mul_done;

    // Effective byte count and masked word
    always_comb begin
        v         = (!in_last || in_vb > 4'd8) ? 4'd8 : in_vb;
        mask      = (64'd1 << {v, 3'b000}) - 64'd1;
        wm        = in_word & mask;
        full_word = (v == 4'd8);
    end

    always_comb begin
        case (cmd.c_sel)
            C_P1:    cval = PRIME1;
            C_P2:    cval = PRIME2;
            C_P3:    cval = PRIME3;
            default: cval = PRIME5;
        endcase
    end

    xxh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .run     (cmd.mul),
        .a       (a_reg),
        .c       (cval),
        .r       (r),
        .done    (mul_done)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= SEED_RESET;
            fill_reg      <= 6'd0;
            len_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                seed_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.clr_fill) begin
                fill_reg <= 6'd0;
            end
            if (cmd.wb == WB_ACCEPT) begin
                len_reg <= len_reg + {60'd0, v};
                if (full_word) begin
                    fill_reg <= fill_reg + 6'd8;
                end
            end else if (cmd.wb == WB_OUT) begin
                len_reg       <= 64'd0;
                fill_reg      <= 6'd0;
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Operand register load
    always_ff @(posedge aclk) begin
        unique case (cmd.a_sel)
            A_NONE:   ;
            A_BUF:    a_reg <= buf_reg[cmd.k];
            A_LSUM:   a_reg <= rol64(lane_reg[cmd.k] + r, 31);
            A_ROT31R: a_reg <= rol64(r, 31);
            A_LANE:   a_reg <= lane_reg[cmd.k];
            A_H:      a_reg <= h_reg;
            A_ROT27H: a_reg <= rol64(h_reg, 27);
            A_ROT23H: a_reg <= rol64(h_reg, 23);
            A_ROT11H: a_reg <= rol64(h_reg, 11);
            A_X32:    a_reg <= {32'd0, x_reg[31:0]};
            A_X8:     a_reg <= {56'd0, x_reg[7:0]};
            default:  ;
        endcase
    end

    // Payload write-back
    always_ff @(posedge aclk) begin
        unique case (cmd.wb)
            WB_NONE: ;
            WB_ACCEPT: begin
                if (len_reg == 64'd0) begin
                    lane_reg[0] <= seed_reg + PRIME1 + PRIME2;
                    lane_reg[1] <= seed_reg + PRIME2;
                    lane_reg[2] <= seed_reg;
                    lane_reg[3] <= seed_reg - PRIME1;
                end
                if (full_word) begin
                    buf_reg[fill_reg[4:3]] <= wm;
                end
                x_reg    <= wm;
                rem_reg  <= full_word ? 3'd0 : v[2:0];
                last_reg <= in_last;
            end
            WB_LANE:  lane_reg[cmd.k] <= r;
            WB_HXOR:  h_reg <= h_reg ^ r;
            WB_HP4:   h_reg <= r + PRIME4;
            WB_T4: begin
                h_reg   <= r + PRIME3;
                x_reg   <= x_reg >> 32;
                rem_reg <= rem_reg - 3'd4;
            end
            WB_T1: begin
                h_reg   <= r;
                x_reg   <= x_reg >> 8;
                rem_reg <= rem_reg - 3'd1;
            end
            WB_HSET:  h_reg <= r;
            WB_MERGE: h_reg <= rol64(lane_reg[0], 1) + rol64(lane_reg[1], 7) +
                               rol64(lane_reg[2], 12) + rol64(lane_reg[3], 18);
            WB_SHORT: h_reg <= lane_reg[2] + PRIME5;
            WB_HLEN:  h_reg <= h_reg + len_reg;
            WB_AV33:  h_reg <= h_reg ^ (h_reg >> 33);
            WB_AV29:  h_reg <= h_reg ^ (h_reg >> 29);
            WB_OUT:   digest_reg <= h_reg ^ (h_reg >> 32);
            default:  ;
        endcase
    end

    always_comb begin
        status.mul_done  = mul_done;
        status.fill_full = fill_reg[5];
        status.last      = last_reg;
        status.len_ge32  = |len_reg[63:5];
        status.nbuf      = fill_reg[4:3];
        status.rem       = rem_reg;
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_digest = digest_reg;

endmodule

/* src/xxh_ctrl.sv */
// Controller: sequences stripe rounds, merge, tail rounds and avalanche over the datapath.
// Depends on xxh_pkg.
module xxh_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  xxh_pkg::xxh_status_t status,
    output xxh_pkg::xxh_cmd_t    cmd
);
    import xxh_pkg::*;

    localparam logic [5:0] S_IDLE   = 6'd0;
    localparam logic [5:0] S_CHK    = 6'd1;
    localparam logic [5:0] S_ST_A   = 6'd2;
    localparam logic [5:0] S_ST_M1  = 6'd3;
    localparam logic [5:0] S_ST_B   = 6'd4;
    localparam logic [5:0] S_ST_M2  = 6'd5;
    localparam logic [5:0] S_ST_W   = 6'd6;
    localparam logic [5:0] S_FIN    = 6'd7;
    localparam logic [5:0] S_MG_A   = 6'd8;
    localparam logic [5:0] S_MG_M1  = 6'd9;
    localparam logic [5:0] S_MG_B   = 6'd10;
    localparam logic [5:0] S_MG_M2  = 6'd11;
    localparam logic [5:0] S_MG_X   = 6'd12;
    localparam logic [5:0] S_MG_C   = 6'd13;
    localparam logic [5:0] S_MG_M3  = 6'd14;
    localparam logic [5:0] S_MG_W   = 6'd15;
    localparam logic [5:0] S_ADDLEN = 6'd16;
    localparam logic [5:0] S_TB_A   = 6'd17;
    localparam logic [5:0] S_TB_M1  = 6'd18;
    localparam logic [5:0] S_TB_B   = 6'd19;
    localparam logic [5:0] S_TB_M2  = 6'd20;
    localparam logic [5:0] S_TB_X   = 6'd21;
    localparam logic [5:0] S_TB_C   = 6'd22;
    localparam logic [5:0] S_TB_M3  = 6'd23;
    localparam logic [5:0] S_TB_W   = 6'd24;
    localparam logic [5:0] S_TAIL4  = 6'd25;
    localparam logic [5:0] S_T4_M   = 6'd26;
    localparam logic [5:0] S_T4_X   = 6'd27;
    localparam logic [5:0] S_T4_C   = 6'd28;
    localparam logic [5:0] S_T4_M2  = 6'd29;
    localparam logic [5:0] S_T4_W   = 6'd30;
    localparam logic [5:0] S_T1     = 6'd31;
    localparam logic [5:0] S_T1_M   = 6'd32;
    localparam logic [5:0] S_T1_X   = 6'd33;
    localparam logic [5:0] S_T1_C   = 6'd34;
    localparam logic [5:0] S_T1_M2  = 6'd35;
    localparam logic [5:0] S_T1_W   = 6'd36;
    localparam logic [5:0] S_AV1    = 6'd37;
    localparam logic [5:0] S_AV1_C  = 6'd38;
    localparam logic [5:0] S_AV1_M  = 6'd39;
    localparam logic [5:0] S_AV1_W  = 6'd40;
    localparam logic [5:0] S_AV2    = 6'd41;
    localparam logic [5:0] S_AV2_C  = 6'd42;
    localparam logic [5:0] S_AV2_M  = 6'd43;
    localparam logic [5:0] S_AV2_W  = 6'd44;
    localparam logic [5:0] S_AV3    = 6'd45;

    logic [5:0] state_reg, state_next;
    logic [1:0] k_reg, k_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and command decode
    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        cmd.a_sel    = A_NONE;
        cmd.c_sel    = C_P1;
        cmd.mul      = 1'b0;
        cmd.wb       = WB_NONE;
        cmd.k        = k_reg;
        cmd.clr_fill = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.wb     = WB_ACCEPT;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                k_next = 2'd0;
                if (status.fill_full) begin
                    state_next = S_ST_A;
                end else if (status.last) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_IDLE;
                end
            end
            // Stripe round on lane k
            S_ST_A: begin
                cmd.a_sel  = A_BUF;
                state_next = S_ST_M1;
            end
            S_ST_M1: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P2;
                if (status.mul_done) state_next = S_ST_B;
            end
            S_ST_B: begin
                cmd.a_sel  = A_LSUM;
                state_next = S_ST_M2;
            end
            S_ST_M2: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P1;
                if (status.mul_done) state_next = S_ST_W;
            end
            S_ST_W: begin
                cmd.wb = WB_LANE;
                if (k_reg == 2'd3) begin
                    cmd.clr_fill = 1'b1;
                    k_next       = 2'd0;
                    state_next   = status.last ? S_FIN : S_IDLE;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_ST_A;
                end
            end
            // Lane merge or short-message start
            S_FIN: begin
                k_next = 2'd0;
                if (status.len_ge32) begin
                    cmd.wb     = WB_MERGE;
                    state_next = S_MG_A;
                end else begin
                    cmd.wb     = WB_SHORT;
                    state_next = S_ADDLEN;
                end
            end
            S_MG_A: begin
                cmd.a_sel  = A_LANE;
                state_next = S_MG_M1;
            end
            S_MG_M1: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P2;
                if (status.mul_done) state_next = S_MG_B;
            end
            S_MG_B: begin
                cmd.a_sel  = A_ROT31R;
                state_next = S_MG_M2;
            end
            S_MG_M2: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P1;
                if (status.mul_done) state_next = S_MG_X;
            end
            S_MG_X: begin
                cmd.wb     = WB_HXOR;
                state_next = S_MG_C;
            end
            S_MG_C: begin
                cmd.a_sel  = A_H;
                state_next = S_MG_M3;
            end
            S_MG_M3: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P1;
                if (status.mul_done) state_next = S_MG_W;
            end
            S_MG_W: begin
                cmd.wb = WB_HP4;
                if (k_reg == 2'd3) begin
                    k_next     = 2'd0;
                    state_next = S_ADDLEN;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_MG_A;
                end
            end
            S_ADDLEN: begin
                cmd.wb     = WB_HLEN;
                k_next     = 2'd0;
                state_next = (status.nbuf != 2'd0) ? S_TB_A : S_TAIL4;
            end
            // Buffered 8-byte tail rounds
            S_TB_A: begin
                cmd.a_sel  = A_BUF;
                state_next = S_TB_M1;
            end
            S_TB_M1: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P2;
                if (status.mul_done) state_next = S_TB_B;
            end
            S_TB_B: begin
                cmd.a_sel  = A_ROT31R;
                state_next = S_TB_M2;
            end
            S_TB_M2: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P1;
                if (status.mul_done) state_next = S_TB_X;
            end
            S_TB_X: begin
                cmd.wb     = WB_HXOR;
                state_next = S_TB_C;
            end
            S_TB_C: begin
                cmd.a_sel  = A_ROT27H;
                state_next = S_TB_M3;
            end
            S_TB_M3: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P1;
                if (status.mul_done) state_next = S_TB_W;
            end
            S_TB_W: begin
                cmd.wb = WB_HP4;
                if (k_reg + 2'd1 == status.nbuf) begin
                    k_next     = 2'd0;
                    state_next = S_TAIL4;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_TB_A;
                end
            end
            // 4-byte tail round
            S_TAIL4: begin
                if (status.rem >= 3'd4) begin
                    cmd.a_sel  = A_X32;
                    state_next = S_T4_M;
                end else begin
                    state_next = S_T1;
                end
            end
            S_T4_M: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P1;
                if (status.mul_done) state_next = S_T4_X;
            end
            S_T4_X: begin
                cmd.wb     = WB_HXOR;
                state_next = S_T4_C;
            end
            S_T4_C: begin
                cmd.a_sel  = A_ROT23H;
                state_next = S_T4_M2;
            end
            S_T4_M2: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P2;
                if (status.mul_done) state_next = S_T4_W;
            end
            S_T4_W: begin
                cmd.wb     = WB_T4;
                state_next = S_T1;
            end
            // 1-byte tail rounds
            S_T1: begin
                if (status.rem != 3'd0) begin
                    cmd.a_sel  = A_X8;
                    state_next = S_T1_M;
                end else begin
                    state_next = S_AV1;
                end
            end
            S_T1_M: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P5;
                if (status.mul_done) state_next = S_T1_X;
            end
            S_T1_X: begin
                cmd.wb     = WB_HXOR;
                state_next = S_T1_C;
            end
            S_T1_C: begin
                cmd.a_sel  = A_ROT11H;
                state_next = S_T1_M2;
            end
            S_T1_M2: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P1;
                if (status.mul_done) state_next = S_T1_W;
            end
            S_T1_W: begin
                cmd.wb     = WB_T1;
                state_next = S_T1;
            end
            // Avalanche
            S_AV1: begin
                cmd.wb     = WB_AV33;
                state_next = S_AV1_C;
            end
            S_AV1_C: begin
                cmd.a_sel  = A_H;
                state_next = S_AV1_M;
            end
            S_AV1_M: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P2;
                if (status.mul_done) state_next = S_AV1_W;
            end
            S_AV1_W: begin
                cmd.wb     = WB_HSET;
                state_next = S_AV2;
            end
            S_AV2: begin
                cmd.wb     = WB_AV29;
                state_next = S_AV2_C;
            end
            S_AV2_C: begin
                cmd.a_sel  = A_H;
                state_next = S_AV2_M;
            end
            S_AV2_M: begin
                cmd.mul   = 1'b1;
                cmd.c_sel = C_P3;
                if (status.mul_done) state_next = S_AV2_W;
            end
            S_AV2_W: begin
                cmd.wb     = WB_HSET;
                state_next = S_AV3;
            end
            // Hold until the output register is free
            S_AV3: begin
                if (status.out_free) begin
                    cmd.wb     = WB_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            k_reg     <= 2'd0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

/* src/xxhash64_stream.sv */
// xxHash64 over a stream of little-endian 64-bit words. A word that neither completes a
// stripe nor ends the message passes only the accept and check states; a completed 32-byte
// stripe adds four lane rounds of two multiplies each on the one shared 32x32 multiplier.
// The last word adds merge, tail rounds and avalanche, plus any wait for the output register.
// Reset (aresetn low, synchronous) restores the seed to its default and clears length,
// fill count, sequencer and the output valid flag.
module xxhash64_stream (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] data_word, [67:64] valid_bytes, [71:68] zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);
    import xxh_pkg::*;

    xxh_cmd_t    cmd;
    xxh_status_t status;

    assign cfg_ready = 1'b1;

    xxh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    xxh_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_word    (s_tdata[63:0]),
        .in_vb      (s_tdata[67:64]),
        .in_last    (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_digest (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // No request is taken while the multiplier is running
    a_no_accept_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.mul) else $error("request accepted during multiply");

    // One word at a time: the sequencer leaves idle after every request
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready held after request");

    // Multiplier completion only under a multiply command
    a_done_with_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        status.mul_done |-> cmd.mul) else $error("stray multiplier completion");
`endif

endmodule

/* test/xxhash64_stream_test.sv */
// Self-checking testbench for xxhash64_stream: drives messages of little-endian words,
// predicts each XXH64 digest in place and compares it. Depends on xxh_pkg and the block.
`timescale 1ns / 100ps

module xxhash64_stream_test;
    import xxh_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] cfg_data = '0;

    xxhash64_stream dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predictor state
    logic [63:0] hash_seed;
    logic [63:0] lanes [4];
    logic [63:0] stripe [4];
    int unsigned fill_words;
    logic [63:0] msg_len;

    logic [63:0] digest_q[$];
    int          mismatches = 0;
    int          digests_seen = 0;
    int          words_sent = 0;
    bit          hold_off = 1'b0;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] lane_mix(input logic [63:0] acc, input logic [63:0] w);
        return rotl(acc + w * PRIME2, 31) * PRIME1;
    endfunction

    task automatic reload_lanes();
        lanes[0] = hash_seed + PRIME1 + PRIME2;
        lanes[1] = hash_seed + PRIME2;
        lanes[2] = hash_seed;
        lanes[3] = hash_seed - PRIME1;
    endtask

    // Advance the hash state by one word; queue the digest on a last word
    task automatic hash_word(input logic [63:0] wd, input logic [3:0] vb, input bit lst);
        int unsigned n;
        int unsigned rem;
        logic [63:0] w;
        logic [63:0] h;
        logic [63:0] x;
        n = (!lst || vb > 8) ? 8 : vb;
        w = (n < 8) ? (wd & ((64'd1 << (8 * n)) - 1)) : wd;
        if (msg_len == 0)
            reload_lanes();
        msg_len += n;
        if (n == 8) begin
            stripe[fill_words] = w;
            fill_words++;
            if (fill_words == 4) begin
                for (int i = 0; i < 4; i++)
                    lanes[i] = lane_mix(lanes[i], stripe[i]);
                fill_words = 0;
            end
        end
        if (!lst)
            return;
        if (msg_len >= 32) begin
            h = rotl(lanes[0], 1) + rotl(lanes[1], 7) + rotl(lanes[2], 12) + rotl(lanes[3], 18);
            for (int i = 0; i < 4; i++)
                h = ((h ^ lane_mix(0, lanes[i])) * PRIME1) + PRIME4;
        end else begin
            h = lanes[2] + PRIME5;
        end
        h += msg_len;
        for (int i = 0; i < fill_words; i++)
            h = rotl(h ^ lane_mix(0, stripe[i]), 27) * PRIME1 + PRIME4;
        if (n < 8) begin
            rem = n;
            x = w;
            if (rem >= 4) begin
                h ^= (x & 64'hffffffff) * PRIME1;
                h = rotl(h, 23) * PRIME2 + PRIME3;
                x >>= 32;
                rem -= 4;
            end
            while (rem != 0) begin
                h ^= (x & 64'hff) * PRIME5;
                h = rotl(h, 11) * PRIME1;
                x >>= 8;
                rem--;
            end
        end
        h ^= h >> 33;
        h *= PRIME2;
        h ^= h >> 29;
        h *= PRIME3;
        h ^= h >> 32;
        digest_q = {digest_q, h};
        fill_words = 0;
        msg_len = 0;
    endtask

    // Offer one word and predict at acceptance; sometimes drop valid for a random gap after it
    task automatic send_word(input logic [63:0] wd, input logic [3:0] vb, input bit lst);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, vb, wd};
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        hash_word(wd, vb, lst);
        words_sent++;
        if ($urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic write_seed(input logic [63:0] value);
        wait (digest_q.size() == 0);
        repeat (120) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        hash_seed = value;
    endtask

    // Random message: mostly short, sometimes several stripes long
    task automatic send_message();
        int unsigned nw;
        logic [3:0] vb;
        nw = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 9);
        for (int i = 1; i < nw; i++)
            send_word({$urandom, $urandom}, 4'($urandom), 1'b0);
        vb = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        if (vb == 0 && nw == 1)
            vb = 4'd1;
        send_word({$urandom, $urandom}, vb, 1'b1);
    endtask

    // Check results against the oldest expected digest
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            digests_seen++;
            if (digest_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest %h", m_tdata);
            end else begin
                if (m_tdata !== digest_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: expected %h got %h", digest_q[0], m_tdata);
                end
                void'(digest_q.pop_front());
            end
        end
    end

    // Receiver stalls on its own pattern; a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    // Directed table: data word, valid bytes, last flag
    typedef struct {
        logic [63:0] wd;
        logic [3:0]  vb;
        bit          lst;
    } word_row_t;

    word_row_t dir_rows[] = '{
        '{64'h0, 4'd1, 1'b1},
        '{64'hffffffffffffffff, 4'd8, 1'b1},
        '{64'hffffffffffffffff, 4'd15, 1'b1},
        '{64'h0123456789abcdef, 4'd4, 1'b1},
        '{64'hfedcba9876543210, 4'd7, 1'b1},
        '{64'h1111111111111111, 4'd3, 1'b0},
        '{64'h2222222222222222, 4'd0, 1'b1},
        '{64'haaaaaaaaaaaaaaaa, 4'd8, 1'b0},
        '{64'h5555555555555555, 4'd8, 1'b0},
        '{64'hffffffffffffffff, 4'd8, 1'b0},
        '{64'h0, 4'd8, 1'b0},
        '{64'h8000000000000001, 4'd5, 1'b1},
        '{64'h1, 4'd8, 1'b0},
        '{64'h2, 4'd8, 1'b0},
        '{64'h3, 4'd8, 1'b0},
        '{64'h4, 4'd8, 1'b0},
        '{64'h5, 4'd8, 1'b0},
        '{64'h6, 4'd8, 1'b0},
        '{64'h7, 4'd8, 1'b1}
    };

    initial begin
        hash_seed = SEED_RESET;
        fill_words = 0;
        msg_len = 0;
        reload_lanes();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table under the default seed, starting with a one-byte zero message
        foreach (dir_rows[i])
            send_word(dir_rows[i].wd, dir_rows[i].vb, dir_rows[i].lst);
        s_tvalid <= 1'b0;

        // Seed change mid-message: applies only from the next message
        send_word(64'h99, 4'd8, 1'b0);
        s_tvalid <= 1'b0;
        wait (digest_q.size() == 0);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= 64'h0;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        send_word(64'h77, 4'd2, 1'b1);
        hash_seed = 64'h0;
        s_tvalid <= 1'b0;

        // Random messages under several seeds, extremes included
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_seed(64'h0);
                1: write_seed(64'hffffffffffffffff);
                2: write_seed({$urandom, $urandom});
                default: write_seed(SEED_RESET);
            endcase
            // Long receiver hold-off in the second phase
            if (ph == 1)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            while (words_sent < 420 * (ph + 1))
                send_message();
            s_tvalid <= 1'b0;
        end

        wait (digest_q.size() == 0);
        repeat (200) @(posedge aclk);
        $display("sent %0d words, checked %0d digests over four seeds", words_sent,
                 digests_seen);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #8000000;
        $display("timeout with %0d digests outstanding", digest_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
